// ===== design/rot_pkg.sv =====
// Shared types and constants of the resource ownership table.
package rot_pkg;

   localparam int MODE_W      = 3;
   localparam int OWNER_W     = 16;
   localparam int RES_W       = 32;
   localparam int RANGE_W     = 16;
   localparam int PERM_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int REMOVED_W   = 7;
   localparam int LIMIT_W     = 16;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [MODE_W-1:0] MODE_BIND   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PAGES  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BLOCKS = 3'd2;
   localparam logic [MODE_W-1:0] MODE_VERIFY = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REVOKE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BOUND = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_PAGE_LIMIT  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLOCK_LIMIT = 1'b1;

   localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET  = 16'd1024;
   localparam logic [LIMIT_W-1:0] BLOCK_LIMIT_RESET = 16'd2048;

   typedef struct packed {
      logic [RES_W-1:0]   resource;
      logic [OWNER_W-1:0] owner;
      logic [PERM_W-1:0]  permissions;
   } rot_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 granted;
      logic [REMOVED_W-1:0] removed_count;
   } rot_result_type;

   typedef struct packed {
      logic           valid;
      rot_result_type result;
   } rot_done_type;

endpackage

// ===== design/rot_interfaces.sv =====
// Request, response and register write channels of the resource ownership table.
interface rot_req_if import rot_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [OWNER_W-1:0] owner;
   logic [RES_W-1:0]   res_id;
   logic [RANGE_W-1:0] range_count;
   logic [PERM_W-1:0]  permissions;

   modport source (output valid, mode, owner, res_id, range_count, permissions,
                   input ready);
   modport sink   (input valid, mode, owner, res_id, range_count, permissions,
                   output ready);
endinterface

interface rot_rsp_if import rot_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 granted;
   logic [REMOVED_W-1:0] removed_count;

   modport source (output valid, status, granted, removed_count, input ready);
   modport sink   (input valid, status, granted, removed_count, output ready);
endinterface

interface rot_csr_if import rot_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== design/resource_ownership_table_core.sv =====
// Top level of the resource ownership table: limit registers and response register.
//
// req_chan carries one request beat (mode, owner, res_id, range_count,
// permissions); every request gives exactly one beat on rsp_chan (status,
// granted, removed_count). csr_chan writes page_limit (addr 0) and
// block_limit (addr 1); it is always ready and should be used while idle.
// Requests are handled one at a time out of a table memory with one write
// port and a registered read port, one stored entry scanned per cycle;
// req_chan is ready only while the sequencer is idle.
// A single bind scans every stored entry and then appends, stops on a
// duplicate, or finishes without a scan when the table is full; verify
// stops early on a hit; revoke scans every entry, compacting the table in
// place during its scan. A range bind repeats the single bind per id; out
// of range or empty range finishes without a scan. The sequencer returns
// to idle once its response is taken into the output register.
// The response sits in an output register, so the next request is taken
// while a finished response still waits; a stalled rsp_chan holds its beat
// and stops the sequencer only once a second response is ready.
// Reset empties the table and restores limits to 1024 and 2048.
module resource_ownership_table_core import rot_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   rot_req_if.sink    req_chan,
   rot_rsp_if.source  rsp_chan,
   rot_csr_if.sink    csr_chan
);

   logic [LIMIT_W-1:0] page_limit_ff, page_limit_in;
   logic [LIMIT_W-1:0] block_limit_ff, block_limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rot_result_type     rsp_data_ff, rsp_data_in;
   rot_done_type       done;
   logic               take;

   rot_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .page_limit  (page_limit_ff),
      .block_limit (block_limit_ff),
      .take        (take),
      .done        (done)
   );

   assign take = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      page_limit_in  = page_limit_ff;
      block_limit_in = block_limit_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            CSR_PAGE_LIMIT:  page_limit_in  = csr_chan.data;
            CSR_BLOCK_LIMIT: block_limit_in = csr_chan.data;
            default: begin
            end
         endcase
      end
      if (take) begin
         rsp_valid_in = done.valid;
         if (done.valid) begin
            rsp_data_in = done.result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_limit_ff  <= PAGE_LIMIT_RESET;
         block_limit_ff <= BLOCK_LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         page_limit_ff  <= page_limit_in;
         block_limit_ff <= block_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.granted       = rsp_data_ff.granted;
   assign rsp_chan.removed_count = rsp_data_ff.removed_count;

endmodule

// ===== design/rot_engine.sv =====
// Table memory and request sequencer: scan, append and compacting revoke.
module rot_engine import rot_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   rot_req_if.sink            req,
   input  logic [LIMIT_W-1:0] page_limit,
   input  logic [LIMIT_W-1:0] block_limit,
   input  logic               take,
   output rot_done_type       done
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIND_START,
      ST_SCAN,
      ST_REVOKE,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic               pend_ff, pend_in;
   logic               verify_ff, verify_in;
   logic [RES_W-1:0]   cur_id_ff, cur_id_in;
   logic [RANGE_W-1:0] remaining_ff, remaining_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [PERM_W-1:0]  perm_ff, perm_in;
   rot_result_type     result_ff, result_in;

   rot_entry_type      mem [TABLE_DEPTH];
   rot_entry_type      rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   rot_entry_type      wr_data;

   logic               hit;
   logic               at_end;
   logic [CW-1:0]      kept_next;
   logic [RES_W:0]     range_end;
   logic [LIMIT_W-1:0] limit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign hit    = pend_ff && (rd_data_ff.resource == cur_id_ff);
   assign at_end = (issue_ff == count_ff);
   assign limit  = (req.mode == MODE_PAGES) ? page_limit : block_limit;
   assign range_end = {1'b0, req.res_id} + {{(RES_W + 1 - RANGE_W){1'b0}}, req.range_count};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      kept_in      = kept_ff;
      pend_in      = 1'b0;
      verify_in    = verify_ff;
      cur_id_in    = cur_id_ff;
      remaining_in = remaining_ff;
      owner_in     = owner_ff;
      perm_in      = perm_ff;
      result_in    = result_ff;
      rd_addr      = issue_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{resource: cur_id_ff, owner: owner_ff, permissions: perm_ff};
      kept_next    = kept_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               owner_in     = req.owner;
               perm_in      = req.permissions;
               cur_id_in    = req.res_id;
               remaining_in = RANGE_W'(1);
               result_in    = '0;
               issue_in     = '0;
               kept_in      = '0;
               verify_in    = 1'b0;
               case (req.mode)
                  MODE_BIND: begin
                     state_in = ST_BIND_START;
                  end
                  MODE_PAGES, MODE_BLOCKS: begin
                     remaining_in = req.range_count;
                     if (range_end > {{(RES_W + 1 - LIMIT_W){1'b0}}, limit}) begin
                        result_in.status = STATUS_FULL;
                        state_in = ST_FINISH;
                     end else if (req.range_count == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_BIND_START;
                     end
                  end
                  MODE_VERIFY: begin
                     verify_in = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  MODE_REVOKE: begin
                     state_in = ST_REVOKE;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_BIND_START: begin
            issue_in = '0;
            if (count_ff == FULL_COUNT) begin
               result_in.status = STATUS_FULL;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (verify_ff) begin
                  result_in.granted = (rd_data_ff.owner == owner_ff) &&
                                      ((rd_data_ff.permissions & perm_ff) != '0);
               end else begin
                  result_in.status = STATUS_BOUND;
               end
               state_in = ST_FINISH;
            end else if (at_end) begin
               if (verify_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  wr_en        = 1'b1;
                  count_in     = count_ff + CW'(1);
                  cur_id_in    = cur_id_ff + RES_W'(1);
                  remaining_in = remaining_ff - RANGE_W'(1);
                  if (remaining_ff == RANGE_W'(1)) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_BIND_START;
                  end
               end
            end else begin
               issue_in = issue_ff + CW'(1);
               pend_in  = 1'b1;
            end
         end
         ST_REVOKE: begin
            if (pend_ff && (rd_data_ff.owner != owner_ff)) begin
               wr_en     = 1'b1;
               wr_addr   = kept_ff[AW-1:0];
               wr_data   = rd_data_ff;
               kept_next = kept_ff + CW'(1);
            end
            kept_in = kept_next;
            if (at_end) begin
               count_in = kept_next;
               result_in.removed_count = REMOVED_W'(count_ff - kept_next);
               state_in = ST_FINISH;
            end else begin
               issue_in = issue_ff + CW'(1);
               pend_in  = 1'b1;
            end
         end
         ST_FINISH: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         kept_ff      <= kept_in;
         verify_ff    <= verify_in;
         cur_id_ff    <= cur_id_in;
         remaining_ff <= remaining_in;
         owner_ff     <= owner_in;
         perm_ff      <= perm_in;
         result_ff    <= result_in;
      end
   end

   assign req.ready    = (state_ff == ST_IDLE);
   assign done.valid   = (state_ff == ST_FINISH);
   assign done.result  = result_ff;

endmodule

// ===== tb/rot_tb_pkg.sv =====
// Request type and response scoreboard for the resource ownership table bench.
package rot_tb_pkg;
   import rot_pkg::*;

   localparam int TABLE_SLOTS = 64;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [OWNER_W-1:0] owner;
      logic [RES_W-1:0]   res_id;
      logic [RANGE_W-1:0] range_count;
      logic [PERM_W-1:0]  permissions;
   } rot_request_type;

   class ownership_scoreboard;
      logic [LIMIT_W-1:0] page_limit;
      logic [LIMIT_W-1:0] block_limit;
      int unsigned        used;
      rot_entry_type      slots [TABLE_SLOTS];
      rot_result_type     expected_q [$];
      int                 errors;
      int                 checked;
      int                 grants;
      int                 revoked_total;
      int                 fulls;
      int                 dupes;

      function new();
         page_limit    = PAGE_LIMIT_RESET;
         block_limit   = BLOCK_LIMIT_RESET;
         used          = 0;
         errors        = 0;
         checked       = 0;
         grants        = 0;
         revoked_total = 0;
         fulls         = 0;
         dupes         = 0;
      endfunction

      function void write_limit(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_PAGE_LIMIT:  page_limit  = data;
            CSR_BLOCK_LIMIT: block_limit = data;
            default: ;
         endcase
      endfunction

      function logic [STATUS_W-1:0] append(logic [RES_W-1:0] id, logic [OWNER_W-1:0] own,
                                           logic [PERM_W-1:0] perm);
         if (used >= TABLE_SLOTS)
            return STATUS_FULL;
         for (int i = 0; i < used; i++)
            if (slots[i].resource == id)
               return STATUS_BOUND;
         slots[used].resource    = id;
         slots[used].owner       = own;
         slots[used].permissions = perm;
         used++;
         return STATUS_OK;
      endfunction

      function logic [STATUS_W-1:0] bind_span(logic [RES_W-1:0] start,
                                              logic [RANGE_W-1:0] count,
                                              logic [OWNER_W-1:0] own,
                                              logic [PERM_W-1:0] perm,
                                              logic [LIMIT_W-1:0] limit);
         logic [STATUS_W-1:0] st;
         // bound check without wrap
         if ({32'd0, start} + {48'd0, count} > {48'd0, limit})
            return STATUS_FULL;
         for (int i = 0; i < int'(count); i++) begin
            st = append(RES_W'(start + i), own, perm);
            if (st != STATUS_OK)
               return st;
         end
         return STATUS_OK;
      endfunction

      function logic lookup(logic [RES_W-1:0] id, logic [OWNER_W-1:0] own,
                            logic [PERM_W-1:0] perm);
         for (int i = 0; i < used; i++)
            if (slots[i].resource == id)
               return (slots[i].owner == own) && ((slots[i].permissions & perm) != '0);
         return 1'b0;
      endfunction

      function logic [REMOVED_W-1:0] revoke(logic [OWNER_W-1:0] own);
         int unsigned kept;
         int unsigned gone;
         kept = 0;
         for (int i = 0; i < used; i++) begin
            if (slots[i].owner != own) begin
               slots[kept] = slots[i];
               kept++;
            end
         end
         gone = used - kept;
         used = kept;
         return REMOVED_W'(gone);
      endfunction

      function void note_request(rot_request_type rq);
         rot_result_type res;
         res = '0;
         case (rq.mode)
            MODE_BIND:   res.status = append(rq.res_id, rq.owner, rq.permissions);
            MODE_PAGES:  res.status = bind_span(rq.res_id, rq.range_count, rq.owner,
                                                rq.permissions, page_limit);
            MODE_BLOCKS: res.status = bind_span(rq.res_id, rq.range_count, rq.owner,
                                                rq.permissions, block_limit);
            MODE_VERIFY: res.granted = lookup(rq.res_id, rq.owner, rq.permissions);
            MODE_REVOKE: res.removed_count = revoke(rq.owner);
            default: ;
         endcase
         if (res.status == STATUS_FULL)
            fulls++;
         if (res.status == STATUS_BOUND)
            dupes++;
         if (res.granted)
            grants++;
         revoked_total += res.removed_count;
         expected_q.push_back(res);
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= 30)
            $display("mismatch on %s: got %0h, expected %0h (response %0d)",
                     what, got, want, checked);
      endfunction

      function void check_response(rot_result_type got);
         rot_result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report("unexpected response beat", 32'(got), 32'd0);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
         if (got.granted !== want.granted)
            report("granted", 32'(got.granted), 32'(want.granted));
         if (got.removed_count !== want.removed_count)
            report("removed_count", 32'(got.removed_count), 32'(want.removed_count));
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
// Top-level bench: drives requests and limit writes, checks every response beat.
module tb import rot_pkg::*, rot_tb_pkg::*; ();

   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int PHASES       = 5;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 500;

   logic clock;
   logic reset;

   rot_req_if req_bus ();
   rot_rsp_if rsp_bus ();
   rot_csr_if csr_bus ();

   resource_ownership_table_core #(.TABLE_DEPTH(TABLE_SLOTS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   ownership_scoreboard sb = new();

   bit calm;
   bit rsp_hold;
   bit hold_done;
   int cycles;
   int sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycles, sb.expected_q.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm || rsp_hold)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [OWNER_W-1:0] pick_owner();
      if ($urandom_range(0, 9) == 0)
         return OWNER_W'($urandom);
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'hFFFF;
         default: return 16'h5A5A;
      endcase
   endfunction

   function automatic rot_request_type mk(logic [MODE_W-1:0] mode, logic [OWNER_W-1:0] own,
                                          logic [RES_W-1:0] id, logic [RANGE_W-1:0] count,
                                          logic [PERM_W-1:0] perm);
      rot_request_type rq;
      rq.mode        = mode;
      rq.owner       = own;
      rq.res_id      = id;
      rq.range_count = count;
      rq.permissions = perm;
      return rq;
   endfunction

   function automatic rot_request_type random_request();
      rot_request_type rq;
      int              r;
      int              lim;
      rq.owner       = pick_owner();
      rq.permissions = PERM_W'($urandom_range(0, 255));
      rq.range_count = RANGE_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 80)
         rq.res_id = $urandom_range(0, 95);
      else if (r < 90)
         rq.res_id = 32'hFFFF_FFFF - $urandom_range(0, 7);
      else
         rq.res_id = $urandom;
      r = $urandom_range(0, 99);
      if (r < 30)
         rq.mode = MODE_BIND;
      else if (r < 40)
         rq.mode = MODE_PAGES;
      else if (r < 48)
         rq.mode = MODE_BLOCKS;
      else if (r < 80)
         rq.mode = MODE_VERIFY;
      else if (r < 96)
         rq.mode = MODE_REVOKE;
      else
         rq.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      if (rq.mode == MODE_PAGES || rq.mode == MODE_BLOCKS) begin
         lim = (rq.mode == MODE_PAGES) ? int'(sb.page_limit) : int'(sb.block_limit);
         r = $urandom_range(0, 99);
         if (r < 30)
            rq.res_id = (lim > 10) ? lim - $urandom_range(0, 10) : $urandom_range(0, lim);
         r = $urandom_range(0, 99);
         if (r < 85)
            rq.range_count = RANGE_W'($urandom_range(0, 6));
         else if (r < 95)
            rq.range_count = RANGE_W'($urandom_range(0, 70));
      end
      return rq;
   endfunction

   task automatic send_request(input rot_request_type rq);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= rq.mode;
      req_bus.owner       <= rq.owner;
      req_bus.res_id      <= rq.res_id;
      req_bus.range_count <= rq.range_count;
      req_bus.permissions <= rq.permissions;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(rq);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_limit(input logic [CSR_ADDR_W-1:0] addr,
                              input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= addr;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.write_limit(addr, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.expected_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      send_request(mk(MODE_BIND,    16'h0001, 32'h0000_0000, 16'h0000, 8'hFF));
      send_request(mk(MODE_BIND,    16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h01));
      send_request(mk(MODE_BIND,    16'h0000, 32'h0000_0000, 16'h0000, 8'h00));
      send_request(mk(MODE_VERIFY,  16'h0001, 32'h0000_0000, 16'h0000, 8'h80));
      send_request(mk(MODE_VERIFY,  16'hFFFF, 32'h0000_0000, 16'h0000, 8'hFF));
      send_request(mk(MODE_VERIFY,  16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 8'hFE));
      send_request(mk(MODE_VERIFY,  16'h0001, 32'd12345,     16'h0000, 8'hFF));
      send_request(mk(MODE_VERIFY,  16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 8'h00));
      // range ending exactly at the page limit, then one past it
      send_request(mk(MODE_PAGES,   16'h0001, 32'd1020,      16'd4,    8'h0F));
      send_request(mk(MODE_PAGES,   16'h0001, 32'd1021,      16'd4,    8'h0F));
      send_request(mk(MODE_PAGES,   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
      send_request(mk(MODE_PAGES,   16'h0001, 32'd1024,      16'd0,    8'h0F));
      send_request(mk(MODE_PAGES,   16'h0001, 32'd1025,      16'd0,    8'h0F));
      // second id collides: first one stays bound
      send_request(mk(MODE_BLOCKS,  16'hFFFF, 32'd1019,      16'd3,    8'h0F));
      send_request(mk(MODE_VERIFY,  16'hFFFF, 32'd1019,      16'h0000, 8'h01));
      send_request(mk(MODE_BLOCKS,  16'h0000, 32'd2040,      16'd8,    8'hA5));
      send_request(mk(MODE_SPARE_LO, 16'h0001, 32'h0000_0000, 16'hFFFF, 8'hFF));
      send_request(mk(MODE_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
      send_request(mk(MODE_REVOKE,  16'h7777, 32'h0000_0000, 16'h0000, 8'h00));
      send_request(mk(MODE_REVOKE,  16'h0001, 32'h0000_0000, 16'h0000, 8'h00));
      // fill the table partway through a range, then full wins over duplicate
      send_request(mk(MODE_PAGES,   16'h0000, 32'd100,       16'd64,   8'h3C));
      send_request(mk(MODE_BIND,    16'h0001, 32'hFFFF_FFFF, 16'h0000, 8'hFF));
      send_request(mk(MODE_VERIFY,  16'h0000, 32'd150,       16'h0000, 8'h04));
      send_request(mk(MODE_REVOKE,  16'h0000, 32'h0000_0000, 16'h0000, 8'h00));
      send_request(mk(MODE_REVOKE,  16'hFFFF, 32'h0000_0000, 16'h0000, 8'h00));
   endtask

   initial begin
      rot_result_type got;
      int             stall;
      stall     = 0;
      rsp_hold  = 1'b0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status        = rsp_bus.status;
            got.granted       = rsp_bus.granted;
            got.removed_count = rsp_bus.removed_count;
            sb.check_response(got);
         end
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && sb.checked >= HOLD_AFTER) begin
            // long back-pressure while requests keep coming
            hold_done = 1'b1;
            rsp_hold  = 1'b1;
            stall     = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_hold = 1'b0;
            if (calm || $urandom_range(0, 99) < 75) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   initial begin
      calm = 1'b0;
      sent = 0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= '0;
      req_bus.owner       <= '0;
      req_bus.res_id      <= '0;
      req_bus.range_count <= '0;
      req_bus.permissions <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.addr        <= '0;
      csr_bus.data        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: begin
                  write_limit(CSR_PAGE_LIMIT, 16'd1);
                  write_limit(CSR_BLOCK_LIMIT, 16'hFFFF);
               end
               2: begin
                  write_limit(CSR_PAGE_LIMIT, 16'hFFFF);
                  write_limit(CSR_BLOCK_LIMIT, 16'd1);
               end
               3: begin
                  write_limit(CSR_PAGE_LIMIT, CSR_DATA_W'($urandom_range(1, 65535)));
                  write_limit(CSR_BLOCK_LIMIT, CSR_DATA_W'($urandom_range(1, 65535)));
               end
               default: begin
                  write_limit(CSR_PAGE_LIMIT, 16'd300);
                  write_limit(CSR_BLOCK_LIMIT, 16'd70);
               end
            endcase
         end
         if (phase == 0)
            run_directed();
         repeat (RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 49) == 0)
               calm = ~calm;
            send_request(random_request());
         end
         req_bus.valid <= 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report("responses never arrived", 32'(sb.expected_q.size()), 32'd0);
      $display("ran %0d requests across %0d limit settings, %0d responses checked",
               sent, PHASES, sb.checked);
      $display("grants %0d, entries revoked %0d, full/out of range %0d, duplicates %0d",
               sb.grants, sb.revoked_total, sb.fulls, sb.dupes);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
